### rtl/dyp_pkg.sv
// Shared constants and helpers for the direction to yaw/pitch unit.
// Fixed-point formats, arctangent table and Q.28 to Q2.13 rounding.
// No dependencies.
`timescale 1ns / 1ps

package dyp_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Operands are always scaled to 32 bits; the datapath widths follow.
  localparam int OPND_W = 32;
  localparam int SQ_W   = 2 * OPND_W;     // x^2 + z^2 after scaling
  localparam int ROOT_W = OPND_W;         // horizontal length
  localparam int REM_W  = ROOT_W + 2;     // square root partial remainder
  localparam int CORD_W = OPND_W + 4;     // CORDIC coordinates, room for gain
  localparam int ANG_W  = 32;             // Q.28 angle accumulator
  localparam int Q13_W  = ANG_W + 1 - 15; // rounded angle before saturation

  localparam int YAW_W   = 16;
  localparam int PITCH_W = 15;

  localparam logic signed [ANG_W-1:0]   PI_Q28    = 32'sd843314857;
  localparam logic signed [ANG_W:0]     RND_HALF  = 33'sd16384;
  localparam logic signed [Q13_W-1:0]   YAW_LIM   = 18'sd25736;
  localparam logic signed [Q13_W-1:0]   PITCH_LIM = 18'sd12868;

  // atan(2^-i) in Q.28, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q28(input int idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      0:       v = 32'sd210828714;
      1:       v = 32'sd124459457;
      2:       v = 32'sd65760959;
      3:       v = 32'sd33381290;
      4:       v = 32'sd16755422;
      5:       v = 32'sd8385879;
      6:       v = 32'sd4193963;
      7:       v = 32'sd2097109;
      8:       v = 32'sd1048571;
      9:       v = 32'sd524287;
      10:      v = 32'sd262144;
      11:      v = 32'sd131072;
      12:      v = 32'sd65536;
      13:      v = 32'sd32768;
      14:      v = 32'sd16384;
      15:      v = 32'sd8192;
      16:      v = 32'sd4096;
      17:      v = 32'sd2048;
      18:      v = 32'sd1024;
      19:      v = 32'sd512;
      20:      v = 32'sd256;
      21:      v = 32'sd128;
      22:      v = 32'sd64;
      23:      v = 32'sd32;
      24:      v = 32'sd16;
      25:      v = 32'sd8;
      26:      v = 32'sd4;
      27:      v = 32'sd2;
      28:      v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up and drop 15 fraction bits
  function automatic logic signed [Q13_W-1:0] q28_to_q13(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W:0] s;
    s = (ANG_W + 1)'(a) + RND_HALF;
    return s[ANG_W:15];
  endfunction

endpackage

### rtl/direction_to_yaw_pitch_unit.sv
// Direction vector to yaw/pitch converter: squares, pipelined square root
// and two unrolled vectoring CORDICs side by side. Uses dyp_pkg.
`timescale 1ns / 1ps

//  channel | ports                                          | handshake
//  --------+------------------------------------------------+---------------------------
//  input   | in_dir_x, in_dir_y, in_dir_z                   | start && !busy
//  result  | out_yaw_angle, out_pitch_angle                 | out_valid, one cycle
//
// One beat enters per cycle; busy stays low. The pipeline stages, in order, are:
// multiply, sum, one stage per bit of the 32-bit square root, quadrant
// pre-rotation, one stage per CORDIC micro-rotation, round/saturate.
// Synchronous active-low reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so nothing ever holds the pipe.

module direction_to_yaw_pitch_unit
  import dyp_pkg::*;
#(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_dir_x,
  input  logic signed [DATA_WIDTH-1:0] in_dir_y,
  input  logic signed [DATA_WIDTH-1:0] in_dir_z,
  output logic                         out_valid,
  output logic signed [YAW_W-1:0]      out_yaw_angle,
  output logic signed [PITCH_W-1:0]    out_pitch_angle
);

  localparam int HFRAC = OPND_W - DATA_WIDTH;
  localparam int PW    = 2 * DATA_WIDTH;

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage M: squares
  logic                         m_vld_r;
  logic signed [DATA_WIDTH-1:0] m_x_r, m_y_r, m_z_r;
  logic        [PW-1:0]         m_xx_r, m_zz_r;
  logic signed [PW-1:0]         xx_nxt, zz_nxt;

  assign xx_nxt = in_dir_x * in_dir_x;
  assign zz_nxt = in_dir_z * in_dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= accept;
    end
    m_x_r  <= in_dir_x;
    m_y_r  <= in_dir_y;
    m_z_r  <= in_dir_z;
    m_xx_r <= xx_nxt;
    m_zz_r <= zz_nxt;
  end

  // ---------------- stage S: scaled sum of squares
  logic                         s_vld_r;
  logic signed [DATA_WIDTH-1:0] s_x_r, s_y_r, s_z_r;
  logic        [SQ_W-1:0]       s_sq_r;
  logic        [SQ_W-1:0]       sq_nxt;

  assign sq_nxt = (SQ_W'(m_xx_r) + SQ_W'(m_zz_r)) << (2 * HFRAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= m_vld_r;
    end
    s_x_r  <= m_x_r;
    s_y_r  <= m_y_r;
    s_z_r  <= m_z_r;
    s_sq_r <= sq_nxt;
  end

  // ---------------- stages Q: digit-by-digit square root, one root bit each
  logic                         q_vld_r  [ROOT_W];
  logic signed [DATA_WIDTH-1:0] q_x_r    [ROOT_W];
  logic signed [DATA_WIDTH-1:0] q_y_r    [ROOT_W];
  logic signed [DATA_WIDTH-1:0] q_z_r    [ROOT_W];
  logic        [SQ_W-1:0]       q_rad_r  [ROOT_W];
  logic        [REM_W-1:0]      q_rem_r  [ROOT_W];
  logic        [ROOT_W-1:0]     q_root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic                         vld_in;
    logic signed [DATA_WIDTH-1:0] x_in, y_in, z_in;
    logic        [SQ_W-1:0]       rad_in;
    logic        [REM_W-1:0]      rem_in;
    logic        [ROOT_W-1:0]     root_in;
    logic        [REM_W+1:0]      rem_cat, trial;
    logic        [REM_W-1:0]      rem_nxt;
    logic        [ROOT_W-1:0]     root_nxt;

    if (k == 0) begin : g_src
      assign vld_in  = s_vld_r;
      assign x_in    = s_x_r;
      assign y_in    = s_y_r;
      assign z_in    = s_z_r;
      assign rad_in  = s_sq_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_src
      assign vld_in  = q_vld_r[k-1];
      assign x_in    = q_x_r[k-1];
      assign y_in    = q_y_r[k-1];
      assign z_in    = q_z_r[k-1];
      assign rad_in  = q_rad_r[k-1];
      assign rem_in  = q_rem_r[k-1];
      assign root_in = q_root_r[k-1];
    end

    always_comb begin
      rem_cat = {rem_in, rad_in[SQ_W-1 -: 2]};
      trial   = (REM_W + 2)'({root_in, 2'b01});
      if (rem_cat >= trial) begin
        rem_nxt  = REM_W'(rem_cat - trial);
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_cat);
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_vld_r[k] <= 1'b0;
      end else begin
        q_vld_r[k] <= vld_in;
      end
      q_x_r[k]    <= x_in;
      q_y_r[k]    <= y_in;
      q_z_r[k]    <= z_in;
      q_rad_r[k]  <= rad_in << 2;
      q_rem_r[k]  <= rem_nxt;
      q_root_r[k] <= root_nxt;
    end
  end

  // ---------------- stage P: quadrant pre-rotation for both CORDICs
  // y* = yaw (den z, num x), p* = pitch (den h, num y)
  logic                     p_vld_r;
  logic signed [CORD_W-1:0] p_ya_r, p_yb_r, p_pa_r, p_pb_r;
  logic signed [ANG_W-1:0]  p_yang_r, p_pang_r;
  logic                     p_yzero_r, p_pzero_r;

  logic signed [CORD_W-1:0] ya0, yb0, pa0, pb0;
  logic signed [CORD_W-1:0] ya_nxt, yb_nxt, pa_nxt, pb_nxt;
  logic signed [ANG_W-1:0]  yang_nxt, pang_nxt;

  assign ya0 = CORD_W'(q_z_r[ROOT_W-1]) <<< HFRAC;
  assign yb0 = CORD_W'(q_x_r[ROOT_W-1]) <<< HFRAC;
  assign pa0 = signed'(CORD_W'(q_root_r[ROOT_W-1]));
  assign pb0 = CORD_W'(q_y_r[ROOT_W-1]) <<< HFRAC;

  always_comb begin
    ya_nxt   = ya0;
    yb_nxt   = yb0;
    yang_nxt = '0;
    if (ya0[CORD_W-1]) begin
      ya_nxt   = -ya0;
      yb_nxt   = -yb0;
      yang_nxt = yb0[CORD_W-1] ? -PI_Q28 : PI_Q28;
    end
    pa_nxt   = pa0;
    pb_nxt   = pb0;
    pang_nxt = '0;
    if (pa0[CORD_W-1]) begin
      pa_nxt   = -pa0;
      pb_nxt   = -pb0;
      pang_nxt = pb0[CORD_W-1] ? -PI_Q28 : PI_Q28;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= q_vld_r[ROOT_W-1];
    end
    p_ya_r    <= ya_nxt;
    p_yb_r    <= yb_nxt;
    p_yang_r  <= yang_nxt;
    p_yzero_r <= (ya0 == '0) && (yb0 == '0);
    p_pa_r    <= pa_nxt;
    p_pb_r    <= pb_nxt;
    p_pang_r  <= pang_nxt;
    p_pzero_r <= (pa0 == '0) && (pb0 == '0);
  end

  // ---------------- stages C: one micro-rotation each, both angles in parallel
  logic                     c_vld_r   [CORDIC_STEPS];
  logic signed [CORD_W-1:0] c_ya_r    [CORDIC_STEPS];
  logic signed [CORD_W-1:0] c_yb_r    [CORDIC_STEPS];
  logic signed [ANG_W-1:0]  c_yang_r  [CORDIC_STEPS];
  logic                     c_yzero_r [CORDIC_STEPS];
  logic signed [CORD_W-1:0] c_pa_r    [CORDIC_STEPS];
  logic signed [CORD_W-1:0] c_pb_r    [CORDIC_STEPS];
  logic signed [ANG_W-1:0]  c_pang_r  [CORDIC_STEPS];
  logic                     c_pzero_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_q28(i);

    logic                     vld_in, yzero_in, pzero_in;
    logic signed [CORD_W-1:0] ya_in, yb_in, pa_in, pb_in;
    logic signed [ANG_W-1:0]  yang_in, pang_in;
    logic signed [CORD_W-1:0] ya_n, yb_n, pa_n, pb_n;
    logic signed [ANG_W-1:0]  yang_n, pang_n;

    if (i == 0) begin : g_src
      assign vld_in   = p_vld_r;
      assign ya_in    = p_ya_r;
      assign yb_in    = p_yb_r;
      assign yang_in  = p_yang_r;
      assign yzero_in = p_yzero_r;
      assign pa_in    = p_pa_r;
      assign pb_in    = p_pb_r;
      assign pang_in  = p_pang_r;
      assign pzero_in = p_pzero_r;
    end else begin : g_src
      assign vld_in   = c_vld_r[i-1];
      assign ya_in    = c_ya_r[i-1];
      assign yb_in    = c_yb_r[i-1];
      assign yang_in  = c_yang_r[i-1];
      assign yzero_in = c_yzero_r[i-1];
      assign pa_in    = c_pa_r[i-1];
      assign pb_in    = c_pb_r[i-1];
      assign pang_in  = c_pang_r[i-1];
      assign pzero_in = c_pzero_r[i-1];
    end

    // b >= 0 rotates clockwise and adds the angle
    always_comb begin
      if (!yb_in[CORD_W-1]) begin
        ya_n   = ya_in + (yb_in >>> i);
        yb_n   = yb_in - (ya_in >>> i);
        yang_n = yang_in + ATAN_I;
      end else begin
        ya_n   = ya_in - (yb_in >>> i);
        yb_n   = yb_in + (ya_in >>> i);
        yang_n = yang_in - ATAN_I;
      end
      if (!pb_in[CORD_W-1]) begin
        pa_n   = pa_in + (pb_in >>> i);
        pb_n   = pb_in - (pa_in >>> i);
        pang_n = pang_in + ATAN_I;
      end else begin
        pa_n   = pa_in - (pb_in >>> i);
        pb_n   = pb_in + (pa_in >>> i);
        pang_n = pang_in - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_vld_r[i] <= 1'b0;
      end else begin
        c_vld_r[i] <= vld_in;
      end
      c_ya_r[i]    <= ya_n;
      c_yb_r[i]    <= yb_n;
      c_yang_r[i]  <= yang_n;
      c_yzero_r[i] <= yzero_in;
      c_pa_r[i]    <= pa_n;
      c_pb_r[i]    <= pb_n;
      c_pang_r[i]  <= pang_n;
      c_pzero_r[i] <= pzero_in;
    end
  end

  // ---------------- output stage: round to Q2.13 and saturate
  logic                     out_valid_r;
  logic signed [YAW_W-1:0]   out_yaw_r;
  logic signed [PITCH_W-1:0] out_pitch_r;
  logic signed [Q13_W-1:0]  yaw_q13, pitch_q13, yaw_sat, pitch_sat;

  always_comb begin
    yaw_q13   = q28_to_q13(c_yang_r[CORDIC_STEPS-1]);
    pitch_q13 = q28_to_q13(c_pang_r[CORDIC_STEPS-1]);
    priority if (c_yzero_r[CORDIC_STEPS-1]) begin
      yaw_sat = '0;
    end else if (yaw_q13 > YAW_LIM) begin
      yaw_sat = YAW_LIM;
    end else if (yaw_q13 < -YAW_LIM) begin
      yaw_sat = -YAW_LIM;
    end else begin
      yaw_sat = yaw_q13;
    end
    priority if (c_pzero_r[CORDIC_STEPS-1]) begin
      pitch_sat = '0;
    end else if (pitch_q13 > PITCH_LIM) begin
      pitch_sat = PITCH_LIM;
    end else if (pitch_q13 < -PITCH_LIM) begin
      pitch_sat = -PITCH_LIM;
    end else begin
      pitch_sat = pitch_q13;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_vld_r[CORDIC_STEPS-1];
    end
    out_yaw_r   <= yaw_sat[YAW_W-1:0];
    out_pitch_r <= pitch_sat[PITCH_W-1:0];
  end

  assign out_valid       = out_valid_r;
  assign out_yaw_angle   = out_yaw_r;
  assign out_pitch_angle = out_pitch_r;

endmodule

### bench/direction_to_yaw_pitch_unit_test.sv
// Self-checking bench for direction_to_yaw_pitch_unit: directed and random
// direction vectors, yaw/pitch predicted in-bench and compared beat by beat.
// Depends on rtl/dyp_pkg.sv and rtl/direction_to_yaw_pitch_unit.sv.
`timescale 1ns / 1ps

module direction_to_yaw_pitch_unit_test
  import dyp_pkg::*;
();

  localparam int W           = DATA_WIDTH_DEF;
  localparam int ROT_STEPS   = CORDIC_STEPS_DEF;
  localparam int OP_SHIFT    = 32 - W;
  localparam longint HALF_TURN = 64'sd843314857;
  localparam longint YAW_MAX   = 25736;
  localparam longint PITCH_MAX = 12868;
  localparam int RANDOM_BEATS = 1830;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  // atan(2^-i), Q.28 radians
  localparam longint ATAN_Q28 [0:15] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963, 2097109,
    1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192
  };

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
  } dir_beat_t;

  typedef struct packed {
    logic signed [YAW_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
  } angle_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [W-1:0] in_dir_x = '0;
  logic signed [W-1:0] in_dir_y = '0;
  logic signed [W-1:0] in_dir_z = '0;
  logic busy;
  logic out_valid;
  logic signed [YAW_W-1:0]   out_yaw_angle;
  logic signed [PITCH_W-1:0] out_pitch_angle;

  dir_beat_t   vectors_to_send[$];
  angle_pair_t angles_due[$];
  logic took = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   errors = 0;
  int   idle_cycles = 0;

  direction_to_yaw_pitch_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .out_valid      (out_valid),
    .out_yaw_angle  (out_yaw_angle),
    .out_pitch_angle(out_pitch_angle)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned rem, res, probe;
    rem = v;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // vectoring rotation, Q.28 angle of (den, num)
  function automatic longint vector_angle(longint num, longint den);
    longint a, b, ang, sa, sb;
    a = den;
    b = num;
    ang = 0;
    if (a == 0 && b == 0) return 0;
    if (a < 0) begin
      ang = (b >= 0) ? HALF_TURN : -HALF_TURN;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      sa = a >>> i;
      sb = b >>> i;
      if (b >= 0) begin
        a = a + sb;
        b = b - sa;
        ang = ang + ATAN_Q28[i];
      end else begin
        a = a - sb;
        b = b + sa;
        ang = ang - ATAN_Q28[i];
      end
    end
    return ang;
  endfunction

  function automatic longint round_clamp(longint q28, longint lim);
    longint r;
    r = (q28 + 16384) >>> 15;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angle_pair_t yaw_pitch_of(dir_beat_t d);
    longint x, y, z, yaw, pitch;
    longint unsigned sq, horiz;
    angle_pair_t p;
    x = d.x;
    y = d.y;
    z = d.z;
    sq = longint'(x * x) + longint'(z * z);
    horiz = root64(sq << (2 * OP_SHIFT));
    yaw = round_clamp(vector_angle(x <<< OP_SHIFT, z <<< OP_SHIFT), YAW_MAX);
    pitch = round_clamp(vector_angle(y <<< OP_SHIFT, longint'(horiz)), PITCH_MAX);
    p.yaw = yaw[YAW_W-1:0];
    p.pitch = pitch[PITCH_W-1:0];
    return p;
  endfunction

  // mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst_left = $urandom_range(200, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic signed [W-1:0] pick_component();
    logic signed [W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: begin
        case ($urandom_range(3))
          0: v = 16'sh7fff;
          1: v = 16'sh8000;
          2: v = 16'sh0001;
          default: v = 16'shffff;
        endcase
      end
      2: v = W'($urandom_range(16) - 8);
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_vector(int x, int y, int z);
    dir_beat_t d;
    d.x = W'(x);
    d.y = W'(y);
    d.z = W'(z);
    vectors_to_send.push_back(d);
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    dir_beat_t d;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (vectors_to_send.size() != 0) begin
        d = vectors_to_send.pop_front();
        in_dir_x <= d.x;
        in_dir_y <= d.y;
        in_dir_z <= d.z;
        start <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: input beats become expectations, result beats are checked
  always @(posedge clk) begin
    dir_beat_t   d;
    angle_pair_t want;
    took <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        d.x = in_dir_x;
        d.y = in_dir_y;
        d.z = in_dir_z;
        angles_due.push_back(yaw_pitch_of(d));
      end
      if (out_valid !== 1'b0) begin
        if (angles_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result beat yaw=%0d pitch=%0d",
                     $realtime, out_yaw_angle, out_pitch_angle);
        end else begin
          want = angles_due.pop_front();
          if (out_yaw_angle !== want.yaw || out_pitch_angle !== want.pitch) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch yaw exp=%0d got=%0d, pitch exp=%0d got=%0d",
                       $realtime, want.yaw, out_yaw_angle, want.pitch, out_pitch_angle);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid === 1'b1)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("direction_to_yaw_pitch_unit_test: errors");
        $finish;
      end
    end
  end

  initial begin
    // zero vector, pure vertical, axis extremes
    queue_vector(0, 0, 0);
    queue_vector(0, 100, 0);
    queue_vector(0, -100, 0);
    queue_vector(0, 32767, 0);
    queue_vector(0, -32768, 0);
    queue_vector(32767, 32767, 32767);
    queue_vector(-32768, -32768, -32768);
    queue_vector(32767, 0, 0);
    queue_vector(-32768, 0, 0);
    queue_vector(0, 0, 32767);
    // negative forward: +pi start for x >= 0, -pi for x < 0; x = 0 lands on the limit
    queue_vector(0, 0, -32768);
    queue_vector(0, 5, -1);
    queue_vector(1, 0, -32768);
    queue_vector(-1, 0, -32768);
    queue_vector(32767, -32768, -32768);
    queue_vector(-32768, 32767, -1);
    queue_vector(1, 1, 1);
    queue_vector(-1, -1, -1);
    queue_vector(1, -32768, 0);
    queue_vector(0, 32767, 1);
    queue_vector(-32768, 32767, 32767);
    queue_vector(12345, -23456, -30000);
    for (int i = 0; i < RANDOM_BEATS; i++)
      queue_vector(pick_component(), pick_component(), pick_component());

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (vectors_to_send.size() == 0 && !start);
    while (angles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("direction_to_yaw_pitch_unit_test: clean");
    end else begin
      $display("direction_to_yaw_pitch_unit_test: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dyp_pkg.sv
rtl/direction_to_yaw_pitch_unit.sv
bench/direction_to_yaw_pitch_unit_test.sv
